// ----- hdl/lkv_pkg.sv -----
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants of the LRU key/value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

	// Opcode values
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// Configuration port
	localparam int          PADDR_W        = 3;
	localparam logic        REG_CAPACITY   = 1'b0;
	localparam logic [4:0]  CAPACITY_RESET = 5'd16;

	// Request item
	typedef struct packed {
		logic               opcode;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} req_t;

	// Result item
	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
		logic               evicted;
		logic signed [31:0] evicted_key;
	} rsp_t;

	// Classified command passed from front to back
	typedef struct packed {
		logic        put;
		logic [31:0] key;    // masked to the stored key width
		logic [31:0] value;
	} cmd_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// ----- hdl/lkv_ram.sv -----
// ----------------------------------------------------------------------------
// lkv_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/lkv_front.sv -----
// ----------------------------------------------------------------------------
// lkv_front
// Input stage: accept request items, classify them and push them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_front #(
	parameter int KEY_BITS = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire lkv_pkg::req_t  in_data,
	input  wire lkv_pkg::q_stat_t q_stat,
	output logic                push,
	output lkv_pkg::cmd_t       push_cmd
);
	import lkv_pkg::*;

	localparam int          KW       = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam logic [31:0] KEY_MASK = 32'((64'd1 << KW) - 64'd1);

	logic valid_s1;
	cmd_t cmd_s1;
	logic accept;

	assign in_stall = valid_s1 && q_stat.full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !q_stat.full;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Decode the opcode and drop key bits above the stored width
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.put   <= (in_data.opcode == OP_PUT);
			cmd_s1.key   <= in_data.key & KEY_MASK;
			cmd_s1.value <= in_data.value;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/lkv_queue.sv -----
// ----------------------------------------------------------------------------
// lkv_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire lkv_pkg::cmd_t    push_cmd,
	input  wire logic             pop,
	output lkv_pkg::cmd_t         head,
	output lkv_pkg::q_stat_t      q_stat
);
	import lkv_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head         = slot_q[rd_ptr_q];
	assign q_stat.full  = (count_q == 2'd2);
	assign q_stat.empty = (count_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/lkv_back.sv -----
// ----------------------------------------------------------------------------
// lkv_back
// Execution stage: associative key match, LRU rank update, value and key
// storage, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_back #(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [4:0]       capacity,
	input  wire lkv_pkg::cmd_t    head,
	input  wire lkv_pkg::q_stat_t q_stat,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output lkv_pkg::rsp_t         out_data
);
	import lkv_pkg::*;

	localparam int KW   = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int SW   = $clog2(ENTRIES);
	localparam int OW   = $clog2(ENTRIES + 1);
	localparam int CMPW = (OW > 5) ? OW : 5;

	logic [ENTRIES-1:0] valid_q;
	logic [KW-1:0]      key_q  [ENTRIES];
	logic [SW-1:0]      rank_q [ENTRIES];
	logic [OW-1:0]      occ_q;

	logic [ENTRIES-1:0] match;
	logic               hit;
	logic [SW-1:0]      hit_idx;
	logic [SW-1:0]      hit_rank;
	logic [SW-1:0]      lru_idx;
	logic [SW-1:0]      free_idx;
	logic [SW-1:0]      slot;
	logic [OW-1:0]      old_rank;
	logic [CMPW-1:0]    cap_eff;
	logic               full;
	logic               do_hit, do_evict, do_fill, do_touch;

	logic               valid_s2, hit_s2, rd_s2, ev_s2;
	logic [31:0]        val_rdata;
	logic [KW-1:0]      key_rdata;

	// Issue when the result register is free or being emptied
	assign pop       = !q_stat.empty && (!valid_s2 || !out_stall);
	assign out_valid = valid_s2;

	always_comb begin
		cap_eff = CMPW'(capacity);
		if (cap_eff == '0) begin
			cap_eff = CMPW'(1);
		end else if (cap_eff > CMPW'(ENTRIES)) begin
			cap_eff = CMPW'(ENTRIES);
		end
		full = (CMPW'(occ_q) >= cap_eff);
	end

	// Keys are unique among valid entries, so OR-ing masked indices is exact
	always_comb begin
		hit_idx  = '0;
		hit_rank = '0;
		lru_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == head.key[KW-1:0]);
			if (match[i]) begin
				hit_idx  = hit_idx | SW'(i);
				hit_rank = hit_rank | rank_q[i];
			end
			if (valid_q[i] && (rank_q[i] == SW'(occ_q - OW'(1)))) begin
				lru_idx = lru_idx | SW'(i);
			end
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = SW'(i);
			end
		end
		hit      = |match;
		do_hit   = pop && hit;
		do_evict = pop && head.put && !hit && full;
		do_fill  = pop && head.put && !hit && !full;
		do_touch = do_hit || do_evict || do_fill;
		if (do_hit) begin
			slot     = hit_idx;
			old_rank = OW'(hit_rank);
		end else if (do_evict) begin
			slot     = lru_idx;
			old_rank = occ_q - OW'(1);
		end else begin
			slot     = free_idx;
			old_rank = occ_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (do_touch) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (SW'(i) == slot) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (OW'(rank_q[i]) < old_rank)) begin
						rank_q[i] <= rank_q[i] + SW'(1);
					end
				end
			end
			if (do_fill) begin
				valid_q[slot] <= 1'b1;
				occ_q         <= occ_q + OW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_evict || do_fill) begin
			key_q[slot] <= head.key[KW-1:0];
		end
	end

	lkv_ram #(
		.WIDTH(32),
		.DEPTH(ENTRIES)
	) u_value_ram (
		.clk   (clk),
		.we    (pop && head.put && (hit || do_evict || do_fill)),
		.waddr (slot),
		.wdata (head.value),
		.re    (pop),
		.raddr (hit_idx),
		.rdata (val_rdata)
	);

	lkv_ram #(
		.WIDTH(KW),
		.DEPTH(ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (do_evict || do_fill),
		.waddr (slot),
		.wdata (head.key[KW-1:0]),
		.re    (pop),
		.raddr (lru_idx),
		.rdata (key_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (pop) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			hit_s2 <= hit;
			rd_s2  <= hit && !head.put;
			ev_s2  <= do_evict;
		end
	end

	always_comb begin
		out_data.hit         = hit_s2;
		out_data.read_value  = rd_s2 ? val_rdata : 32'd0;
		out_data.evicted     = ev_s2;
		out_data.evicted_key = ev_s2 ? 32'(key_rdata) : 32'd0;
	end

endmodule

`default_nettype wire

// ----- hdl/lru_key_value_cache_top.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request item is a get (opcode 0) or a put (opcode 1) and yields exactly
// one result item, in order. A get hit returns the stored value and makes the
// entry most recent; a get miss returns hit 0 and read_value 0. A put on a
// present key overwrites the value; a put on a new key takes a free entry, or,
// once the occupancy has reached the capacity register, replaces the least
// recent entry and reports its key in evicted_key. Keys are matched on their
// low KEY_BITS bits (at most 32). The block sustains one item per cycle while
// the result channel is not stalled: the whole match, rank update and write
// of a request happen in the same back-end cycle. A result item passes the
// input register, the command queue and the lookup with registered RAM read
// before it is presented on the result channel. No
// clearing pass runs after reset: only the valid bits, the ranks and the
// occupancy are reset. Capacity 0 acts as 1, capacity above ENTRIES acts as
// ENTRIES, and lowering it below the occupancy evicts nothing at once; each
// later put of a new key then replaces one entry. Write the capacity register
// at byte address 0 only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_top #(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// request channel
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire lkv_pkg::req_t               in_data,
	// result channel
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output lkv_pkg::rsp_t                    out_data,
	// configuration port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lkv_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready
);
	import lkv_pkg::*;

	logic       cap_sel;
	logic [4:0] cap_q;
	logic       push;
	logic       pop;
	cmd_t       push_cmd;
	cmd_t       head;
	q_stat_t    q_stat;

	// Register file: capacity only, decoded on paddr[2]; addresses with paddr[2] set read as zero, drop writes
	assign pready  = 1'b1;
	assign cap_sel = (paddr[2] == REG_CAPACITY);
	assign prdata  = cap_sel ? {27'd0, cap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAPACITY_RESET;
		end else if (psel && penable && pwrite && cap_sel) begin
			cap_q <= pwdata[4:0];
		end
	end

	// Front: accept, decode, mask the key
	lkv_front #(
		.KEY_BITS(KEY_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Queue: decouple front stalls from back stalls
	lkv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// Back: match, update ranks and storage, hold the result
	lkv_back #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (cap_q),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ----- hdl/lkv_checker.sv -----
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks of the LRU key/value cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          out_valid,
	input  wire logic          out_stall,
	input  wire lkv_pkg::rsp_t out_data,
	input  wire logic [31:0]   prdata,
	input  wire logic          pready
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// Eviction only on a miss
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.evicted |-> !out_data.hit)
		else $error("eviction reported on a hit");

	// An evicting put reads no value
	a_evict_noval: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.evicted |-> out_data.read_value == 32'sd0)
		else $error("read value on an evicting put");

	// No evicted key without eviction
	a_evkey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.evicted |-> out_data.evicted_key == 32'sd0)
		else $error("evicted key without eviction");

	// The port is always ready and reads back at most five bits
	a_cfg_read: assert property (@(posedge clk) disable iff (!arst_n)
		pready && (prdata[31:5] == 27'd0))
		else $error("config read out of range");

endmodule

bind lru_key_value_cache_top lkv_checker u_lkv_checker (.*);

`default_nettype wire
